// ===== rtl/length_prefixed_frame_receiver_top_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef LENGTH_PREFIXED_FRAME_RECEIVER_TOP_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LPFR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define LPFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/lpfr_pkg.sv =====
package lpfr_pkg;

	localparam int BYTE_W = 8;
	localparam logic [BYTE_W-1:0] START_RESET = 8'd35;
	localparam logic [BYTE_W-1:0] MIN_LEN = 8'd2;

	typedef enum logic [1:0] {
		ST_HUNT,
		ST_LEN,
		ST_DATA,
		ST_EMIT
	} lpfr_state_t;

	typedef struct packed {
		logic push;
		logic emit;
		logic last;
	} lpfr_ctl_t;

endpackage

// ===== rtl/lpfr_if.sv =====
interface lpfr_rx_if;
	logic valid;
	logic ready;
	logic [lpfr_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface lpfr_frame_if;
	logic valid;
	logic ready;
	logic [lpfr_pkg::BYTE_W-1:0] frame_byte;
	logic frame_last;

	modport source (output valid, output frame_byte, output frame_last, input ready);
	modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface lpfr_cfg_if;
	logic valid;
	logic ready;
	logic [lpfr_pkg::BYTE_W-1:0] start_byte;

	modport source (output valid, output start_byte, input ready);
	modport sink (input valid, input start_byte, output ready);
endinterface

// ===== rtl/length_prefixed_frame_receiver_top.sv =====
// The first frame byte is offered only after the final frame byte transfers in, once
// it has moved through the empty cells to the head, one cell a cycle.
// The input stalls until a frame is out, so no new byte is taken while it is emitted.
// Reset (arst_n low, asynchronous): hunting, cells empty, start byte 35.
module length_prefixed_frame_receiver_top #(
	parameter int MAX_FRAME = 12
) (
	input  logic           clk,
	input  logic           arst_n,
	lpfr_cfg_if.sink       cfg,
	lpfr_rx_if.sink        rx,
	lpfr_frame_if.source   frame
);

	logic [lpfr_pkg::BYTE_W-1:0] start_byte_q;
	lpfr_pkg::lpfr_ctl_t         ctl;
	logic                        head_pop;
	logic                        cell_valid [MAX_FRAME];
	logic [lpfr_pkg::BYTE_W-1:0] cell_data  [MAX_FRAME];
	logic                        cell_ready [MAX_FRAME];

	// Start byte register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= lpfr_pkg::START_RESET;
		end else if (cfg.valid) begin
			start_byte_q <= cfg.start_byte;
		end
	end

	// Frame sequencing
	lpfr_ctrl #(
		.MAX_FRAME (MAX_FRAME)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rx.valid),
		.in_byte     (rx.rx_byte),
		.start_byte  (start_byte_q),
		.chain_ready (cell_ready[0]),
		.out_xfer    (head_pop),
		.in_ready    (rx.ready),
		.ctl         (ctl)
	);

	// Row of byte cells: enter at cell 0, leave from the last cell
	for (genvar i = 0; i < MAX_FRAME; i++) begin : g_cell
		logic                        up_valid;
		logic [lpfr_pkg::BYTE_W-1:0] up_data;
		logic                        down_ready;

		if (i == 0) begin : g_tail
			assign up_valid = ctl.push;
			assign up_data  = rx.rx_byte;
		end else begin : g_mid
			assign up_valid = cell_valid[i-1];
			assign up_data  = cell_data[i-1];
		end

		if (i == MAX_FRAME - 1) begin : g_head
			assign down_ready = head_pop;
		end else begin : g_link
			assign down_ready = cell_ready[i+1];
		end

		lpfr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.up_valid   (up_valid),
			.up_data    (up_data),
			.down_ready (down_ready),
			.valid      (cell_valid[i]),
			.data       (cell_data[i]),
			.ready      (cell_ready[i])
		);
	end

	// Offer the head cell only once the frame is complete
	assign frame.valid      = ctl.emit && cell_valid[MAX_FRAME-1];
	assign frame.frame_byte = cell_data[MAX_FRAME-1];
	assign frame.frame_last = ctl.last;
	assign head_pop         = frame.valid && frame.ready;

endmodule

// ===== rtl/lpfr_cell.sv =====
module lpfr_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	input  logic [lpfr_pkg::BYTE_W-1:0] up_data,
	input  logic                        down_ready,
	output logic                        valid,
	output logic [lpfr_pkg::BYTE_W-1:0] data,
	output logic                        ready
);

	logic                        valid_q;
	logic [lpfr_pkg::BYTE_W-1:0] data_q;

	// Accept from upstream when empty or when the held byte moves on
	assign ready = !valid_q || down_ready;
	assign valid = valid_q;
	assign data  = data_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= up_valid;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ready && up_valid) begin
			data_q <= up_data;
		end
	end

endmodule

// ===== rtl/lpfr_ctrl.sv =====
module lpfr_ctrl #(
	parameter int MAX_FRAME = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [lpfr_pkg::BYTE_W-1:0] in_byte,
	input  logic [lpfr_pkg::BYTE_W-1:0] start_byte,
	input  logic                        chain_ready,
	input  logic                        out_xfer,
	output logic                        in_ready,
	output lpfr_pkg::lpfr_ctl_t         ctl
);

	localparam int PW = $clog2(MAX_FRAME + 1);

	lpfr_pkg::lpfr_state_t state_q, state_d;
	logic [PW-1:0]         pos_q;
	logic [PW-1:0]         len_q;
	logic                  in_xfer;
	logic                  len_bad;
	logic                  data_done;

	assign in_xfer   = in_valid && in_ready;
	assign len_bad   = (in_byte < lpfr_pkg::MIN_LEN) ||
		(in_byte > lpfr_pkg::BYTE_W'(MAX_FRAME));
	assign data_done = (pos_q + PW'(1)) == len_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpfr_pkg::ST_HUNT: begin
				if (in_xfer && (in_byte == start_byte)) state_d = lpfr_pkg::ST_LEN;
			end
			lpfr_pkg::ST_LEN: begin
				if (in_xfer) state_d = len_bad ? lpfr_pkg::ST_HUNT : lpfr_pkg::ST_DATA;
			end
			lpfr_pkg::ST_DATA: begin
				if (in_xfer && data_done) state_d = lpfr_pkg::ST_EMIT;
			end
			lpfr_pkg::ST_EMIT: begin
				if (out_xfer && (pos_q == PW'(1))) state_d = lpfr_pkg::ST_HUNT;
			end
			default: state_d = lpfr_pkg::ST_HUNT;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			lpfr_pkg::ST_HUNT: begin
				in_ready = chain_ready;
			end
			lpfr_pkg::ST_LEN: begin
				in_ready = chain_ready;
				ctl.push = in_xfer && !len_bad;
			end
			lpfr_pkg::ST_DATA: begin
				in_ready = chain_ready;
				ctl.push = in_xfer;
			end
			lpfr_pkg::ST_EMIT: begin
				ctl.emit = 1'b1;
				ctl.last = pos_q == PW'(1);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpfr_pkg::ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// Count stored bytes while collecting, count down while emitting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
		end else begin
			case (state_q)
				lpfr_pkg::ST_LEN: begin
					if (in_xfer && !len_bad) begin
						len_q <= in_byte[PW-1:0];
						pos_q <= PW'(1);
					end
				end
				lpfr_pkg::ST_DATA: begin
					if (in_xfer) begin
						pos_q <= data_done ? len_q : pos_q + PW'(1);
					end
				end
				lpfr_pkg::ST_EMIT: begin
					if (out_xfer) begin
						pos_q <= pos_q - PW'(1);
					end
				end
				default: begin
					pos_q <= pos_q;
				end
			endcase
		end
	end

endmodule

// ===== rtl/lpfr_checker.sv =====
`include "length_prefixed_frame_receiver_top_assert.svh"

module lpfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [lpfr_pkg::BYTE_W-1:0] out_byte,
	input logic                        out_last
);

	// No input is taken while a frame is being given out
	`LPFR_ASSERT_IMPL(a_no_rx_while_emit, out_valid, !in_ready)

	// A stalled frame byte holds
	`LPFR_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))

	// After the final byte transfers the output goes quiet
	`LPFR_ASSERT_NEXT(a_quiet_after_last, out_valid && out_ready && out_last, !out_valid)

endmodule

bind length_prefixed_frame_receiver_top lpfr_checker u_lpfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (rx.ready),
	.out_valid (frame.valid),
	.out_ready (frame.ready),
	.out_byte  (frame.frame_byte),
	.out_last  (frame.frame_last)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam int FRAME_MAX = 12;
	localparam int SETTLE_CYCLES = 3 * FRAME_MAX + 8;
	localparam int LONG_STALL_CYCLES = 90;
	localparam int PHASE_ITEMS = 26;

	typedef struct packed {
		logic [lpfr_pkg::BYTE_W-1:0] data;
		logic                        last;
	} frame_beat_t;

	typedef struct {
		logic [lpfr_pkg::BYTE_W-1:0] value;
		bit                          drain;
	} rx_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpfr_cfg_if   cfg_if ();
	lpfr_rx_if    rx_if ();
	lpfr_frame_if frame_if ();

	length_prefixed_frame_receiver_top #(
		.MAX_FRAME(FRAME_MAX)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_if),
		.rx    (rx_if),
		.frame (frame_if)
	);

	// Deframer shadow state
	logic [lpfr_pkg::BYTE_W-1:0] start_sel = lpfr_pkg::START_RESET;
	bit                          collecting = 1'b0;
	int                          fill_pos = 0;
	int                          frame_len = 0;
	logic [lpfr_pkg::BYTE_W-1:0] frame_buf [FRAME_MAX];

	frame_beat_t due_beats [$];
	rx_item_t    pending_bytes [$];

	int  bytes_queued = 0;
	int  bytes_taken = 0;
	int  faults = 0;
	bit  rx_fired = 1'b0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  long_hold = 1'b0;
	bit  stall_arm = 1'b0;

	always #1 clk = ~clk;

	// Give up well beyond the slowest legal run
	initial begin
		#400000;
		$display("FAIL length_prefixed_frame_receiver_top");
		$finish;
	end

	task automatic report_fault(input string what);
		faults++;
		if (faults <= 10) begin
			$display("%0t: %s", $realtime, what);
		end
	endtask

	// Advance the shadow deframer by one received byte
	task automatic deframe_byte(input logic [lpfr_pkg::BYTE_W-1:0] b);
		int k;
		if (!collecting) begin
			if (b == start_sel) begin
				collecting = 1'b1;
			end
		end else if (fill_pos == 0) begin
			if (b < lpfr_pkg::MIN_LEN || b > FRAME_MAX) begin
				// bad length: abort silently
				collecting = 1'b0;
			end else begin
				frame_len = b;
				frame_buf[0] = b;
				fill_pos = 1;
			end
		end else begin
			frame_buf[fill_pos] = b;
			fill_pos++;
			if (fill_pos == frame_len) begin
				for (k = 0; k < frame_len; k++) begin
					due_beats.push_back('{data: frame_buf[k], last: (k == frame_len - 1)});
				end
				collecting = 1'b0;
				fill_pos = 0;
				frame_len = 0;
			end
		end
	endtask

	// Offer the next pending byte, hold it until it transfers
	always @(negedge clk) begin
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
		end else if (rx_if.valid && !rx_fired) begin
			// hold the current offer
		end else if (pending_bytes.size() != 0
				&& !(pending_bytes[0].drain && due_beats.size() != 0)
				&& $urandom_range(99) >= send_idle_pct) begin
			rx_if.valid <= 1'b1;
			rx_if.rx_byte <= pending_bytes[0].value;
			void'(pending_bytes.pop_front());
		end else begin
			rx_if.valid <= 1'b0;
			rx_if.rx_byte <= $urandom;
		end
	end

	// Randomise frame acceptance, drop ready during the long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_if.ready <= 1'b0;
		end else begin
			frame_if.ready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Track input transfers and check each frame byte against the oldest expectation
	always @(posedge clk) begin
		frame_beat_t want;
		rx_fired = arst_n && rx_if.valid && rx_if.ready;
		if (rx_fired) begin
			deframe_byte(rx_if.rx_byte);
			bytes_taken++;
		end
		if (arst_n && frame_if.valid && frame_if.ready) begin
			if (due_beats.size() == 0) begin
				report_fault($sformatf("unexpected frame byte %h last %b",
					frame_if.frame_byte, frame_if.frame_last));
			end else begin
				want = due_beats.pop_front();
				if (frame_if.frame_byte !== want.data || frame_if.frame_last !== want.last) begin
					report_fault($sformatf("frame byte: expected %h last %b, got %h last %b",
						want.data, want.last, frame_if.frame_byte, frame_if.frame_last));
				end
			end
		end
	end

	// Hold the receiver off for a long stretch once armed
	initial begin
		wait (stall_arm);
		long_hold = 1'b1;
		repeat (LONG_STALL_CYCLES) @(posedge clk);
		long_hold = 1'b0;
	end

	task automatic queue_byte(input logic [lpfr_pkg::BYTE_W-1:0] v, input bit drain = 1'b0);
		pending_bytes.push_back('{value: v, drain: drain});
		bytes_queued++;
	endtask

	task automatic queue_frame(input int len, input bit drain);
		int i;
		queue_byte(start_sel, drain);
		queue_byte(len);
		for (i = 1; i < len; i++) begin
			// now and then put the start byte inside the frame
			if ($urandom_range(7) == 0) begin
				queue_byte(start_sel);
			end else begin
				queue_byte($urandom_range(255));
			end
		end
	endtask

	task automatic queue_noise();
		logic [lpfr_pkg::BYTE_W-1:0] v;
		v = $urandom;
		if (v == start_sel) begin
			v = ~v;
		end
		queue_byte(v);
	endtask

	task automatic queue_bad_length();
		queue_byte(start_sel);
		if ($urandom_range(2) == 0) begin
			queue_byte($urandom_range(1));
		end else begin
			queue_byte($urandom_range(255, FRAME_MAX + 1));
		end
	endtask

	// Mostly well-formed frames, some noise and aborted frames
	task automatic queue_random_phase(input int target);
		int counted;
		int frames;
		int r;
		int len;
		counted = 0;
		frames = 0;
		while (counted < target) begin
			r = $urandom_range(99);
			if (r < 15) begin
				queue_noise();
				counted += 1;
			end else if (r < 27) begin
				queue_bad_length();
				counted += 2;
			end else begin
				len = ($urandom_range(4) == 0) ? FRAME_MAX :
					$urandom_range(FRAME_MAX, lpfr_pkg::MIN_LEN);
				queue_frame(len, frames == 1);
				frames++;
				counted += len + 1;
			end
		end
	endtask

	// Wait until every byte has transferred and every frame byte has come out
	task automatic settle();
		while (bytes_taken != bytes_queued || due_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_start(input logic [lpfr_pkg::BYTE_W-1:0] v);
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.start_byte <= v;
		do @(posedge clk); while (!cfg_if.ready);
		start_sel = v;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin
		logic [lpfr_pkg::BYTE_W-1:0] long_data [FRAME_MAX-1] = '{8'h23, 8'h00, 8'hff, 8'haa,
			8'h55, 8'h01, 8'h02, 8'h80, 8'h7f, 8'h23, 8'hfe};
		int i;

		cfg_if.valid = 1'b0;
		cfg_if.start_byte = '0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		frame_if.ready = 1'b0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: noise, shortest frame, every kind of bad length, longest frame
		send_idle_pct = 35;
		recv_idle_pct = 82;
		queue_byte(8'h00);
		queue_byte(start_sel);
		queue_byte(lpfr_pkg::MIN_LEN);
		queue_byte(8'hff);
		queue_byte(start_sel);
		queue_byte(8'd0);
		queue_byte(start_sel);
		queue_byte(8'd1);
		queue_byte(start_sel);
		queue_byte(FRAME_MAX + 1);
		queue_byte(start_sel);
		queue_byte(8'hff);
		queue_byte(start_sel);
		queue_byte(FRAME_MAX);
		for (i = 0; i < FRAME_MAX - 1; i++) begin
			queue_byte(long_data[i]);
		end
		settle();

		write_start(8'h00);
		queue_random_phase(PHASE_ITEMS);
		settle();

		send_idle_pct = 82;
		recv_idle_pct = 35;
		write_start(8'hff);
		queue_random_phase(PHASE_ITEMS);
		settle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_start($urandom_range(254, 1));
		queue_random_phase(PHASE_ITEMS);
		stall_arm = 1'b1;
		settle();

		if (faults == 0 && due_beats.size() == 0) begin
			$display("PASS length_prefixed_frame_receiver_top");
		end else begin
			$display("FAIL length_prefixed_frame_receiver_top");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lpfr_pkg.sv
rtl/lpfr_if.sv
rtl/lpfr_cell.sv
rtl/lpfr_ctrl.sv
rtl/length_prefixed_frame_receiver_top.sv
rtl/lpfr_checker.sv
verif/tb.sv
